### sv/cre_pkg.sv
// Shared types and constants for the convolution row MAC engine.
// Holds the item structs, the controller command and status structs and the state type.
// No dependencies.
`default_nettype none

package cre_pkg;

    // Layer geometry
    localparam int OUT_CHANNELS = 4;
    localparam int IN_CHANNELS  = 4;
    localparam int TAPS         = 3;
    localparam int OUT_COLS     = 6;
    localparam int OUT_ROWS     = 6;
    localparam int IN_ROWS      = 8;

    // Store depths and address widths
    localparam int W_DEPTH = OUT_CHANNELS * IN_CHANNELS * TAPS;
    localparam int A_DEPTH = IN_CHANNELS * IN_ROWS * OUT_COLS;
    localparam int WA_W    = $clog2(W_DEPTH);
    localparam int AA_W    = $clog2(A_DEPTH);

    // Output channels are walked in pairs
    localparam int MR_COUNT = (OUT_CHANNELS + 1) / 2;
    localparam int MR_W     = (MR_COUNT > 1) ? $clog2(MR_COUNT) : 1;

    typedef logic [WA_W-1:0]     t_waddr;
    typedef logic [AA_W-1:0]     t_aaddr;
    typedef logic [MR_W-1:0]     t_mr;
    typedef logic [1:0]          t_chan;
    typedef logic signed [15:0]  t_q88;
    typedef logic signed [31:0]  t_prod;
    typedef logic signed [35:0]  t_sum;

    typedef enum logic [1:0] {
        OP_WRITE_WEIGHT = 2'd0,
        OP_WRITE_ACT    = 2'd1,
        OP_COMPUTE      = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]        operation;
        logic [1:0]        out_channel;
        logic [1:0]        in_channel;
        logic [1:0]        tap;
        logic [2:0]        in_row;
        logic [2:0]        in_col;
        logic [2:0]        out_row_sel;
        logic signed [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         result_channel;
        logic [2:0]         result_row;
        logic [2:0]         result_col;
        logic signed [35:0] sum;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic wr_weight;
        logic wr_act;
        logic issue;
        logic next_result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_busy;
        logic acc_done;
        logic term_last;
        logic result_last;
    } t_dp_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT_SLOT,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

### sv/cre_ctrl.sv
// Sequencing state machine of the convolution row MAC engine.
// Depends on cre_pkg for the state type, commands and status.
`default_nettype none

module cre_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire cre_pkg::t_in_item  i_in_item,
    input  wire cre_pkg::t_dp_status i_status,
    output logic                    o_in_stall,
    output cre_pkg::t_ctrl_cmd      o_cmd
);

    cre_pkg::t_state r_state;
    cre_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cre_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != cre_pkg::ST_IDLE);
        case (r_state)
            cre_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.operation)
                        cre_pkg::OP_WRITE_WEIGHT: begin
                            o_cmd.wr_weight = 1'b1;
                        end
                        cre_pkg::OP_WRITE_ACT: begin
                            o_cmd.wr_act = 1'b1;
                        end
                        cre_pkg::OP_COMPUTE: begin
                            // drop rows beyond the output
                            if (int'(i_in_item.out_row_sel) < cre_pkg::OUT_ROWS) begin
                                o_cmd.start = 1'b1;
                                n_state     = cre_pkg::ST_WAIT_SLOT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cre_pkg::ST_WAIT_SLOT: begin
                if (!i_status.out_busy) begin
                    n_state = cre_pkg::ST_ISSUE;
                end
            end
            cre_pkg::ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_status.term_last) begin
                    n_state = cre_pkg::ST_DRAIN;
                end
            end
            cre_pkg::ST_DRAIN: begin
                if (i_status.acc_done) begin
                    if (i_status.result_last) begin
                        n_state = cre_pkg::ST_IDLE;
                    end else begin
                        o_cmd.next_result = 1'b1;
                        n_state           = cre_pkg::ST_WAIT_SLOT;
                    end
                end
            end
            default: begin
                n_state = cre_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/cre_datapath.sv
// Datapath of the convolution row MAC engine: weight and activation stores,
// index counters, one pipelined multiply-accumulate unit and the output register.
// Depends on cre_pkg.
`default_nettype none

module cre_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cre_pkg::t_in_item   i_in_item,
    input  wire cre_pkg::t_ctrl_cmd  i_cmd,
    input  wire logic                i_out_stall,
    output cre_pkg::t_dp_status      o_status,
    output logic                     o_out_valid,
    output cre_pkg::t_out_item       o_out_item
);

    // Stores
    cre_pkg::t_q88 r_wmem [cre_pkg::W_DEPTH];
    cre_pkg::t_q88 r_amem [cre_pkg::A_DEPTH];
    cre_pkg::t_q88 r_w_rd;
    cre_pkg::t_q88 r_a_rd;

    // Index counters
    logic [2:0]     r_p;
    cre_pkg::t_mr   r_mr;
    logic           r_mc;
    logic [2:0]     r_q;
    logic [1:0]     r_c;
    logic [1:0]     r_r;

    // MAC pipeline
    logic           r_s1_valid;
    logic           r_s1_live;
    logic           r_s1_first;
    logic           r_s1_last;
    logic           r_s2_valid;
    logic           r_s2_first;
    logic           r_s2_last;
    cre_pkg::t_prod r_prod;
    cre_pkg::t_sum  r_acc;
    cre_pkg::t_sum  n_acc;

    // Output register
    logic               r_out_valid;
    cre_pkg::t_out_item r_out;

    cre_pkg::t_chan  m_cur;
    logic            pair_full;
    logic            term_first;
    logic            term_last;
    logic            result_last;
    logic            acc_done;
    logic [3:0]      h_cur;
    logic            h_live;
    cre_pkg::t_waddr w_rd_addr;
    cre_pkg::t_aaddr a_rd_addr;
    cre_pkg::t_waddr w_wr_addr;
    cre_pkg::t_aaddr a_wr_addr;
    logic            w_wr_ok;
    logic            a_wr_ok;

    assign m_cur     = cre_pkg::t_chan'(2 * int'(r_mr) + int'(r_mc));
    assign pair_full = (2 * int'(r_mr) + 1) < cre_pkg::OUT_CHANNELS;

    assign term_first  = (r_c == '0) && (r_r == '0);
    assign term_last   = (int'(r_c) == cre_pkg::IN_CHANNELS - 1)
                      && (int'(r_r) == cre_pkg::TAPS - 1);
    assign result_last = (int'(r_mr) == cre_pkg::MR_COUNT - 1)
                      && (int'(r_q) == cre_pkg::OUT_COLS - 1)
                      && (r_mc || !pair_full);

    assign h_cur  = {1'b0, r_p} + {2'b00, r_r};
    assign h_live = int'(h_cur) < cre_pkg::IN_ROWS;

    assign w_rd_addr = cre_pkg::t_waddr'((int'(m_cur) * cre_pkg::IN_CHANNELS + int'(r_c))
                                         * cre_pkg::TAPS + int'(r_r));
    assign a_rd_addr = cre_pkg::t_aaddr'((int'(r_c) * cre_pkg::IN_ROWS + int'(h_cur))
                                         * cre_pkg::OUT_COLS + int'(r_q));

    assign w_wr_addr = cre_pkg::t_waddr'((int'(i_in_item.out_channel) * cre_pkg::IN_CHANNELS
                                          + int'(i_in_item.in_channel)) * cre_pkg::TAPS
                                         + int'(i_in_item.tap));
    assign a_wr_addr = cre_pkg::t_aaddr'((int'(i_in_item.in_channel) * cre_pkg::IN_ROWS
                                          + int'(i_in_item.in_row)) * cre_pkg::OUT_COLS
                                         + int'(i_in_item.in_col));

    assign w_wr_ok = (int'(i_in_item.out_channel) < cre_pkg::OUT_CHANNELS)
                  && (int'(i_in_item.in_channel) < cre_pkg::IN_CHANNELS)
                  && (int'(i_in_item.tap) < cre_pkg::TAPS);
    assign a_wr_ok = (int'(i_in_item.in_channel) < cre_pkg::IN_CHANNELS)
                  && (int'(i_in_item.in_row) < cre_pkg::IN_ROWS)
                  && (int'(i_in_item.in_col) < cre_pkg::OUT_COLS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_weight && w_wr_ok) begin
            r_wmem[w_wr_addr] <= i_in_item.value;
        end
        r_w_rd <= r_wmem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_act && a_wr_ok) begin
            r_amem[a_wr_addr] <= i_in_item.value;
        end
        r_a_rd <= r_amem[a_rd_addr];
    end

    // Counters: term index inner, result index outer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p  <= '0;
            r_mr <= '0;
            r_mc <= 1'b0;
            r_q  <= '0;
            r_c  <= '0;
            r_r  <= '0;
        end else if (i_cmd.start) begin
            r_p  <= i_in_item.out_row_sel;
            r_mr <= '0;
            r_mc <= 1'b0;
            r_q  <= '0;
            r_c  <= '0;
            r_r  <= '0;
        end else begin
            if (i_cmd.issue) begin
                if (int'(r_r) == cre_pkg::TAPS - 1) begin
                    r_r <= '0;
                    if (int'(r_c) == cre_pkg::IN_CHANNELS - 1) begin
                        r_c <= '0;
                    end else begin
                        r_c <= r_c + 2'd1;
                    end
                end else begin
                    r_r <= r_r + 2'd1;
                end
            end
            if (i_cmd.next_result) begin
                if (!r_mc && pair_full) begin
                    r_mc <= 1'b1;
                end else begin
                    r_mc <= 1'b0;
                    if (int'(r_q) == cre_pkg::OUT_COLS - 1) begin
                        r_q  <= '0;
                        r_mr <= r_mr + cre_pkg::t_mr'(1);
                    end else begin
                        r_q <= r_q + 3'd1;
                    end
                end
            end
        end
    end

    // MAC pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
        end
    end

    assign n_acc = r_s2_first ? cre_pkg::t_sum'(r_prod)
                              : r_acc + cre_pkg::t_sum'(r_prod);

    always_ff @(posedge i_clk) begin
        r_s1_live  <= h_live;
        r_s1_first <= term_first;
        r_s1_last  <= term_last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        // rows beyond the store contribute zero
        r_prod     <= r_s1_live ? cre_pkg::t_prod'(r_w_rd) * cre_pkg::t_prod'(r_a_rd) : '0;
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
    end

    assign acc_done = r_s2_valid && r_s2_last;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc_done) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_done) begin
            r_out.result_channel <= m_cur;
            r_out.result_row     <= r_p;
            r_out.result_col     <= r_q;
            r_out.sum            <= n_acc;
            r_out.last           <= result_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.out_busy    = r_out_valid;
    assign o_status.acc_done    = acc_done;
    assign o_status.term_last   = term_last;
    assign o_status.result_last = result_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_done |-> !r_out_valid)
        else $error("sum landed on an occupied output register");

    a_advance_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.next_result |-> acc_done)
        else $error("result counters advanced before the sum landed");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_done |-> (!r_s1_valid && !i_cmd.issue))
        else $error("term of the next sum in flight at completion");

    a_no_issue_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> !(i_cmd.wr_weight || i_cmd.wr_act || i_cmd.start))
        else $error("store write or row start during term issue");

endmodule

`default_nettype wire

### sv/conv_row_mac_engine.sv
// Convolution row MAC engine, top level. Store writes complete when accepted.
// A compute transaction yields 24 sums, one at a time; each sum waits for the output
// register to empty, then issues 12 multiply-accumulate terms through the single shared
// MAC, whose operand read and product registers feed the accumulator and the output
// register. The next transaction is accepted once the last sum is in the output register.
// Synchronous active-low reset clears control state only; the stores are not cleared.
`default_nettype none

module conv_row_mac_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    input  wire cre_pkg::t_in_item  i_in_item,
    output logic                    o_in_stall,
    // result channel
    output logic                    o_out_valid,
    output cre_pkg::t_out_item      o_out_item,
    input  wire logic               i_out_stall
);

    // Controller to datapath: commands (start a row, write a store
    // entry, issue one term, advance to the next sum).
    cre_pkg::t_ctrl_cmd  cmd;
    // Datapath to controller: output slot busy, sum complete, last term of
    // the current sum, last sum of the row.
    cre_pkg::t_dp_status status;

    // The controller only accepts a transaction while idle; a compute
    // transaction holds the input side stalled until its final sum is in
    // the output register, which then drains independently.
    cre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Stores, counters, MAC pipeline and output register. Sums leave in
    // pair order: channel pair outer, column, then channel within the pair.
    cre_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
